// ===== hw/rtl/fat_cluster_chain_engine_assert.svh =====
// assertion macros used by the checker file of the cluster chain engine
`ifndef FAT_CLUSTER_CHAIN_ENGINE_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_ASSERT_SVH

// checked on every rising edge outside reset
`define FCCE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every rising edge, reset included
`define FCCE_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/fcce_pkg.sv =====
// shared types, codes and constants of the cluster chain engine
`default_nettype none

package fcce_pkg;

  localparam int unsigned ClustersDef        = 4096;
  localparam int unsigned EntriesPerBlockDef = 128;

  localparam int unsigned OpW      = 3;
  localparam int unsigned ClusterW = 12;
  localparam int unsigned DataW    = 32;
  localparam int unsigned TotalW   = 13;
  localparam int unsigned BlockW   = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [TotalW-1:0] TotalClustersRst = TotalW'(4096);
  localparam logic [BlockW-1:0] FatFirstBlockRst = BlockW'(32);
  localparam logic [DataW-1:0]  LastMarkerRst    = 32'h0FFF_FFFF;
  localparam logic [DataW-1:0]  FreeMarkerRst    = 32'h0000_0000;

  typedef enum logic [OpW-1:0] {
    OP_WRITE     = 3'd0,
    OP_READ      = 3'd1,
    OP_LENGTH    = 3'd2,
    OP_LAST      = 3'd3,
    OP_PRED      = 3'd4,
    OP_NEXT_FREE = 3'd5,
    OP_COUNTS    = 3'd6
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FAIL  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL_CLUSTERS  = 2'd0,
    CFG_FAT_FIRST_BLOCK = 2'd1,
    CFG_LAST_MARKER     = 2'd2,
    CFG_FREE_MARKER     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TotalW-1:0] total_clusters;
    logic [BlockW-1:0] fat_first_block;
    logic [DataW-1:0]  last_marker;
    logic [DataW-1:0]  free_marker;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0]  value;
    logic [TotalW-1:0] used;
    status_e           status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fat_cluster_chain_engine.sv =====
// Cluster chain engine: a FAT-style cluster table held in a synchronous ram.
// Request channel (in_valid_i / in_stall_o) carries opcode, cluster and value;
// a request is taken at a rising edge with valid high and stall low.
// Result channel (out_valid_o / out_stall_i) carries result_value, used_count
// and status, exactly one result per request, held in an output register.
// One request is in flight at a time, and a walk or scan reads one table entry
// per cycle through the single ram read port. Chain walks read the entries
// visited, next free the entries scanned and counts every entry up to the
// scan limit.
// Config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at once and
// must only be issued while no request is in flight.
// A new request is taken while a finished result still waits for the receiver;
// a further result waits inside until the output register is free.
// Reset clears the sequencer and the output valid flag and restores register
// defaults; table entries are undefined until written, no clearing pass.
`default_nettype none

module fat_cluster_chain_engine import fcce_pkg::*; #(
  parameter int unsigned Clusters        = ClustersDef,
  parameter int unsigned EntriesPerBlock = EntriesPerBlockDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OpW-1:0]      opcode_i,
  input  wire logic [ClusterW-1:0] cluster_i,
  input  wire logic [DataW-1:0]    value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [DataW-1:0]         result_value_o,
  output logic [TotalW-1:0]        used_count_o,
  output logic [StatusW-1:0]       status_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [DataW-1:0]    cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(Clusters);

  cfg_t    cfg_q;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [DataW-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_clusters  <= TotalClustersRst;
      cfg_q.fat_first_block <= FatFirstBlockRst;
      cfg_q.last_marker     <= LastMarkerRst;
      cfg_q.free_marker     <= FreeMarkerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TOTAL_CLUSTERS:  cfg_q.total_clusters  <= cfg_wdata_i[TotalW-1:0];
        CFG_FAT_FIRST_BLOCK: cfg_q.fat_first_block <= cfg_wdata_i[BlockW-1:0];
        CFG_LAST_MARKER:     cfg_q.last_marker     <= cfg_wdata_i;
        CFG_FREE_MARKER:     cfg_q.free_marker     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  fcce_ctrl #(
    .Clusters        (Clusters),
    .EntriesPerBlock (EntriesPerBlock)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .cluster_i   (cluster_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // a write and a later read of the same entry never fall in the same cycle
  fcce_ram #(
    .Width (DataW),
    .Depth (Clusters)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_q.value;
  assign used_count_o   = out_q.used;
  assign status_o       = out_q.status;

endmodule

`default_nettype wire

// ===== hw/rtl/fcce_ram.sv =====
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module fcce_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcce_ctrl.sv =====
// sequencer: decodes a request, walks or scans the table ram one entry a cycle
`default_nettype none

module fcce_ctrl import fcce_pkg::*; #(
  parameter  int unsigned Clusters        = ClustersDef,
  parameter  int unsigned EntriesPerBlock = EntriesPerBlockDef,
  localparam int unsigned AddrW           = $clog2(Clusters)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OpW-1:0]      opcode_i,
  input  wire logic [ClusterW-1:0] cluster_i,
  input  wire logic [DataW-1:0]    value_i,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output result_t                  res_o,
  output logic                     mem_we_o,
  output logic [AddrW-1:0]         mem_waddr_o,
  output logic [DataW-1:0]         mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AddrW-1:0]         mem_raddr_o,
  input  wire logic [DataW-1:0]    mem_rdata_i
);

  localparam int unsigned CntW  = $clog2(Clusters + 1);
  // block = cluster / EntriesPerBlock by reciprocal multiply, exact for 12-bit clusters
  localparam int unsigned DivL  = $clog2(EntriesPerBlock);
  localparam int unsigned DivS  = ClusterW + DivL;
  localparam int unsigned DivM  = ((1 << DivS) + EntriesPerBlock - 1) / EntriesPerBlock;
  localparam int unsigned ProdW = ClusterW + DivS + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_COUNT = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DataW-1:0]  tgt_q, tgt_d;
  logic [DataW-1:0]  cur_q, cur_d;
  logic [DataW-1:0]  prev_q, prev_d;
  logic [CntW-1:0]   step_q, step_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   free_q, free_d;
  logic [CntW-1:0]   used_q, used_d;
  result_t           res_q, res_d;

  logic [CntW-1:0]     lim;
  logic                cl_in_table;
  logic [ProdW-1:0]    div_prod;
  logic [ClusterW-1:0] block_idx;
  logic [DataW-1:0]    block_addr;
  logic [DataW-1:0]    nxt;
  logic [CntW-1:0]     step_nx;
  logic [CntW-1:0]     idx_nx;
  logic                hit_free;

  always_comb begin
    if (DataW'(cfg_i.total_clusters) < DataW'(Clusters)) begin
      lim = CntW'(cfg_i.total_clusters);
    end else begin
      lim = CntW'(Clusters);
    end
  end

  assign cl_in_table = DataW'(cluster_i) < DataW'(Clusters);
  assign div_prod    = ProdW'(cluster_i) * ProdW'(DivM);
  assign block_idx   = div_prod[DivS +: ClusterW];
  assign block_addr  = DataW'(cfg_i.fat_first_block) + DataW'(block_idx);

  assign nxt      = mem_rdata_i;
  assign step_nx  = step_q + CntW'(1);
  assign idx_nx   = idx_q + CntW'(1);
  assign hit_free = mem_rdata_i == cfg_i.free_marker;

  assign mem_waddr_o = AddrW'(cluster_i);
  assign mem_wdata_o = value_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    tgt_d       = tgt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    step_d      = step_q;
    idx_d       = idx_q;
    free_d      = free_q;
    used_d      = used_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(opcode_i);
          tgt_d   = value_i;
          res_d   = '{value: '0, used: '0, status: STS_OK};
          state_d = ST_FIN;
          unique case (op_e'(opcode_i))
            OP_WRITE: begin
              if (cl_in_table) begin
                mem_we_o    = 1'b1;
                res_d.value = block_addr;
              end else begin
                res_d.status = STS_RANGE;
              end
            end
            OP_READ: begin
              if (cl_in_table) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AddrW'(cluster_i);
                state_d     = ST_READ;
              end else begin
                res_d.status = STS_RANGE;
              end
            end
            OP_LENGTH, OP_LAST, OP_PRED: begin
              // an empty chain has length zero
              if (op_e'(opcode_i) == OP_LENGTH && cluster_i == '0) begin
                state_d = ST_FIN;
              end else if (!cl_in_table) begin
                res_d.status = STS_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AddrW'(cluster_i);
                cur_d       = DataW'(cluster_i);
                prev_d      = DataW'(cluster_i);
                step_d      = '0;
                state_d     = ST_WALK;
              end
            end
            OP_NEXT_FREE: begin
              if (DataW'(cluster_i) < DataW'(lim)) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AddrW'(cluster_i);
                idx_d       = CntW'(cluster_i);
                state_d     = ST_SCAN;
              end else begin
                res_d.status = STS_FAIL;
              end
            end
            OP_COUNTS: begin
              if (lim != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                free_d      = '0;
                used_d      = '0;
                state_d     = ST_COUNT;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end

      ST_READ: begin
        res_d.value = mem_rdata_i;
        state_d     = ST_FIN;
      end

      ST_WALK: begin
        // target test comes before the end-of-chain test
        if (op_q == OP_PRED && nxt == tgt_q) begin
          res_d.value = prev_q;
          state_d     = ST_FIN;
        end else if (nxt == cfg_i.last_marker) begin
          if (op_q == OP_PRED) begin
            res_d.status = STS_FAIL;
          end else if (op_q == OP_LENGTH) begin
            res_d.value = DataW'(step_nx);
          end else begin
            res_d.value = cur_q;
          end
          state_d = ST_FIN;
        end else begin
          prev_d = nxt;
          cur_d  = nxt;
          step_d = step_nx;
          if (step_nx == CntW'(Clusters)) begin
            // table size reached without an end: chain loops
            res_d.status = STS_FAIL;
            state_d      = ST_FIN;
          end else if (!(nxt < DataW'(Clusters))) begin
            res_d.status = STS_RANGE;
            state_d      = ST_FIN;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = nxt[AddrW-1:0];
          end
        end
      end

      ST_SCAN: begin
        if (hit_free) begin
          res_d.value = DataW'(idx_q);
          state_d     = ST_FIN;
        end else if (idx_nx == lim) begin
          res_d.status = STS_FAIL;
          state_d      = ST_FIN;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_nx[AddrW-1:0];
          idx_d       = idx_nx;
        end
      end

      ST_COUNT: begin
        if (hit_free) begin
          free_d = free_q + CntW'(1);
        end else begin
          used_d = used_q + CntW'(1);
        end
        if (idx_nx == lim) begin
          res_d.value = DataW'(free_d);
          res_d.used  = TotalW'(used_d);
          state_d     = ST_FIN;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_nx[AddrW-1:0];
          idx_d       = idx_nx;
        end
      end

      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    tgt_q  <= tgt_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    step_q <= step_d;
    idx_q  <= idx_d;
    free_q <= free_d;
    used_q <= used_d;
    res_q  <= res_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign res_valid_o = state_q == ST_FIN;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcce_checker.sv =====
// port-level checks of the cluster chain engine, bound to the top level
`default_nettype none

`include "fat_cluster_chain_engine_assert.svh"

module fcce_checker import fcce_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [DataW-1:0]    result_value_o,
  input wire logic [StatusW-1:0]  status_o
);

  // one request in flight: busy right after a request is taken
  `FCCE_ASSERT(a_busy_after_req, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after request")

  // no result can appear on the edge right after a request
  `FCCE_ASSERT(a_no_instant_result, (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o), "result too early")

  // every failing status reports a zero result
  `FCCE_ASSERT(a_fail_zero, (out_valid_o && (status_o != STS_OK)) |-> (result_value_o == '0), "nonzero result on error")

  `FCCE_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_value_o) && $stable(status_o)), "stalled result changed")

  `FCCE_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind fat_cluster_chain_engine fcce_checker u_checker (.*);

`default_nettype wire
